[rtl/core/spi_pkg.sv]
`timescale 1ns / 1ps
package spi_pkg;
    localparam int MaxPoints  = 16;
    localparam int SpeedWidth = 16;
    localparam int PosW       = 17;
    localparam int QposW      = 18;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;
    localparam int TdataW     = 56;

    localparam logic [1:0] CfgMode  = 2'd0;
    localparam logic [1:0] CfgStart = 2'd1;
    localparam logic [1:0] CfgEnd   = 2'd2;
    localparam logic [1:0] CfgCount = 2'd3;

    localparam logic [1:0] ModeConst  = 2'd0;
    localparam logic [1:0] ModeLinear = 2'd1;
    localparam logic [1:0] ModeCubic  = 2'd2;

    localparam logic [PosW-1:0] PosOne = 17'h10000;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch query position
        logic rd_issue;  // start table read of the next scan slot
        logic check;     // evaluate bracket on read data
        logic use_ends;  // set blend sources to start/end, weight = p
        logic div_start;
        logic div_step;
        logic mul_step;  // advance arithmetic sequencer one step
        logic take_t;    // t into weight path
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic div_done;
        logic mul_done;
    } t_sts;
endpackage

[rtl/core/spi_ram.sv]
`timescale 1ns / 1ps
module spi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[rtl/core/spi_datapath.sv]
`timescale 1ns / 1ps
module spi_datapath import spi_pkg::*; #(
    parameter int MAX_POINTS  = MaxPoints,
    parameter int SPEED_WIDTH = SpeedWidth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic                          i_wr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_widx,
    input  logic [PosW-1:0]               i_wpos,
    input  logic [SPEED_WIDTH-1:0]        i_wspd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_ridx,
    input  logic [QposW-1:0]              i_qpos,
    input  logic [1:0]                    i_mode,
    input  logic [SPEED_WIDTH-1:0]        i_start,
    input  logic [SPEED_WIDTH-1:0]        i_end,
    output logic [SPEED_WIDTH-1:0]        o_speed
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = SPEED_WIDTH;

    logic [PosW-1:0] w_pos_rd;
    logic [SW-1:0]   w_spd_rd;
    logic [AW-1:0]   r_raddr;
    logic [PosW-1:0] r_p, n_p;
    logic [PosW-1:0] r_x0;
    logic [SW-1:0]   r_s0;
    logic            r_prev_ok;
    logic [SW-1:0]   r_a, r_b;
    logic [PosW-1:0] r_den;
    logic [33:0]     r_rem;
    logic [16:0]     r_quo;
    logic [4:0]      r_dcnt;
    logic            r_ddone;
    logic [PosW-1:0] r_t;
    logic [2:0]      r_mstep;
    logic [63:0]     r_acc;
    logic [33:0]     r_t2;
    logic [50:0]     r_t3;
    logic [PosW-1:0] r_w;
    logic [SW+17:0]  r_bl;
    logic            r_mdone;
    logic [34:0]     w_sub;

    spi_ram #(.WIDTH(PosW), .DEPTH(MAX_POINTS)) u_pos (
        .i_clk(i_clk), .i_we(i_wr), .i_waddr(i_widx), .i_wdata(i_wpos),
        .i_raddr(r_raddr), .o_rdata(w_pos_rd));
    spi_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_spd (
        .i_clk(i_clk), .i_we(i_wr), .i_waddr(i_widx), .i_wdata(i_wspd),
        .i_raddr(r_raddr), .o_rdata(w_spd_rd));

    always_comb begin
        if (i_qpos[QposW-1]) begin
            n_p = '0;
        end else if (i_qpos[PosW-1:0] > PosOne) begin
            n_p = PosOne;
        end else begin
            n_p = i_qpos[PosW-1:0];
        end
    end

    assign o_sts.hit = r_prev_ok && (r_p >= r_x0) && (r_p <= w_pos_rd);
    assign o_sts.div_done = r_ddone;
    assign o_sts.mul_done = r_mdone;
    assign w_sub = {1'b0, r_rem} - {2'b0, r_den, 16'd0};

    // step 0..6: t^2, t^3, 3t^2<<16 - 2t^3 rounded, select weight, blend a, blend b, round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ok <= 1'b0;
            r_ddone   <= 1'b0;
            r_mdone   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_p       <= n_p;
                r_prev_ok <= 1'b0;
                r_raddr   <= '0;
            end
            if (i_cmd.rd_issue) begin
                r_raddr <= i_ridx;
            end
            if (i_cmd.check) begin
                r_x0      <= w_pos_rd;
                r_s0      <= w_spd_rd;
                r_prev_ok <= 1'b1;
                r_a       <= r_s0;
                r_b       <= w_spd_rd;
                r_den     <= w_pos_rd - r_x0;
            end
            if (i_cmd.use_ends) begin
                r_a <= i_start;
                r_b <= i_end;
                r_t <= r_p;
            end
            if (i_cmd.div_start) begin
                r_rem   <= {1'b0, r_p - r_x0, 16'd0};
                r_quo   <= '0;
                r_dcnt  <= '0;
                r_ddone <= (w_pos_rd == r_x0);
            end
            if (i_cmd.div_step && !r_ddone) begin
                // restoring division, one quotient bit per cycle, 17 bits
                if (!w_sub[34]) begin
                    r_rem <= {w_sub[32:0], 1'b0};
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[32:0], 1'b0};
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 5'd1;
                if (r_dcnt == 5'd16) begin
                    r_ddone <= 1'b1;
                end
            end
            if (i_cmd.take_t) begin
                r_t     <= (r_den == '0) ? '0 : ((r_quo > PosOne) ? PosOne : r_quo);
                r_mstep <= '0;
                r_mdone <= 1'b0;
            end
            if (i_cmd.use_ends) begin
                r_mstep <= '0;
                r_mdone <= 1'b0;
            end
            if (i_cmd.mul_step && !r_mdone) begin
                r_mstep <= r_mstep + 3'd1;
                case (r_mstep)
                    3'd0: r_t2 <= r_t * r_t;
                    3'd1: r_t3 <= r_t2[32:0] * r_t;
                    3'd2: begin
                        r_acc <= ({30'd0, r_t2} * 64'd3 << 16) - {12'd0, r_t3, 1'b0}
                                 + 64'h8000_0000;
                        if (i_mode == ModeLinear) begin
                            r_w <= r_t;
                        end else begin
                            r_w <= '0;
                        end
                    end
                    3'd3: begin
                        if (i_mode != ModeLinear) begin
                            r_w <= r_acc[48:32];
                        end
                        r_bl <= '0;
                    end
                    3'd4: r_bl <= r_a * (PosOne - r_w);
                    3'd5: r_bl <= r_bl + r_b * r_w;
                    default: begin
                        o_speed <= r_bl[SW+15:16] + {{(SW-1){1'b0}}, r_bl[15]};
                        r_mdone <= 1'b1;
                    end
                endcase
            end
        end
    end
endmodule

[rtl/core/spi_ctrl.sv]
`timescale 1ns / 1ps
module spi_ctrl import spi_pkg::*; #(
    parameter int MAX_POINTS = MaxPoints
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_query,
    input  logic [1:0]                    i_mode,
    input  logic [4:0]                    i_count,
    input  t_sts                          i_sts,
    input  logic                          i_out_full,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_ridx,
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_const
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SScan = 3'd2, SDiv = 3'd3,
                           SMul = 3'd4, SOut = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [CW:0] r_idx;
    logic [CW:0] w_n;
    logic        r_const;

    assign w_n = ({1'b0, i_count} > (CW+1)'(MAX_POINTS)) ? (CW+1)'(MAX_POINTS)
               : (CW+1)'(i_count);
    assign o_ridx = r_idx[AW-1:0];
    assign o_busy = (r_state != SIdle);
    assign o_const = r_const;

    always_comb begin
        o_cmd   = '0;
        o_done  = 1'b0;
        n_state = r_state;
        case (r_state)
            SIdle: if (i_query) begin
                o_cmd.load = 1'b1;
                n_state    = SRead;
            end
            SRead: n_state = SScan;  // table read in flight (slot 0 after a load, the next slot during the scan)
            SScan: begin
                if (i_mode == ModeConst) begin
                    n_state = SOut;
                end else if (w_n == '0) begin
                    o_cmd.use_ends = 1'b1;
                    n_state        = SMul;
                end else if (i_sts.hit) begin
                    o_cmd.check     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = SDiv;
                end else if (r_idx + 1'b1 >= w_n) begin
                    o_cmd.use_ends = 1'b1;
                    n_state        = SMul;
                end else begin
                    o_cmd.check    = 1'b1;
                    o_cmd.rd_issue = 1'b1;
                    n_state        = SRead;
                end
            end
            SDiv: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.take_t = 1'b1;
                    n_state      = SMul;
                end
            end
            SMul: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = SOut;
                end
            end
            SOut: begin
                // wait here while the output register still holds an untaken result
                if (!i_out_full) begin
                    o_done  = 1'b1;
                    n_state = SIdle;
                end
            end
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_idx   <= '0;
            r_const <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_idx   <= '0;
                r_const <= (i_mode == ModeConst);
            end else if (r_state == SScan && o_cmd.rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end
endmodule

[rtl/core/speed_profile_interpolator.sv]
`timescale 1ns / 1ps
// a query is latched and, except in constant mode, the table is scanned slot by slot;
// constant mode goes straight to the output, no points or no bracketing pair skip
// the division, and a bracketing pair runs the division and then the multiply chain
// throughput: one query in flight, next one accepted the cycle after its result loads
// a point write is accepted only while idle; a finished query waits while the output is still full
// reset (i_rst_n low, synchronous): mode cubic, speeds and count zero, table undefined
module speed_profile_interpolator import spi_pkg::*; #(
    parameter int MAX_POINTS  = MaxPoints,
    parameter int SPEED_WIDTH = SpeedWidth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // action, point_index, point_position, point_speed, query_position
    input  logic [TdataW-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // speed
    output logic [SPEED_WIDTH-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxW-1:0]    i_cfg_idx,
    input  logic [CfgDataW-1:0]   i_cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = SPEED_WIDTH;

    logic [1:0]  r_mode;
    logic [SW-1:0] r_start, r_end;
    logic [4:0]  r_count;
    logic        r_ovalid;
    logic [SW-1:0] r_odata;
    t_cmd        w_cmd, w_cmd_dp;
    t_sts        w_sts;
    logic [AW-1:0] w_ridx;
    logic        w_busy, w_done, w_const, w_acc, w_wr, w_lin_ends, w_out_full;
    logic [SW-1:0] w_speed;
    logic [1:0]  w_mode_dp;

    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_wr  = w_acc && !s_axis_tdata[0]
                && ({28'd0, s_axis_tdata[4:1]} < 32'(MAX_POINTS));
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign w_out_full    = r_ovalid && !m_axis_tready;

    // unbracketed or single point: linear even in cubic mode
    assign w_lin_ends = w_cmd.use_ends && (r_count != '0);
    logic r_lin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= 1'b0;
        end else if (w_cmd.load) begin
            r_lin <= 1'b0;
        end else if (w_lin_ends) begin
            r_lin <= 1'b1;
        end
    end
    assign w_mode_dp = r_lin ? ModeLinear : r_mode;
    assign w_cmd_dp = w_cmd;

    spi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_query(w_acc && s_axis_tdata[0]),
        .i_mode(r_mode), .i_count(r_count), .i_sts(w_sts), .i_out_full(w_out_full),
        .o_cmd(w_cmd), .o_ridx(w_ridx), .o_busy(w_busy), .o_done(w_done),
        .o_const(w_const));

    spi_datapath #(.MAX_POINTS(MAX_POINTS), .SPEED_WIDTH(SW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd_dp), .o_sts(w_sts),
        .i_wr(w_wr), .i_widx(AW'(s_axis_tdata[4:1])), .i_wpos(s_axis_tdata[21:5]),
        .i_wspd(SW'(s_axis_tdata[37:22])), .i_ridx(w_ridx + 1'b1),
        .i_qpos(s_axis_tdata[55:38]), .i_mode(w_mode_dp), .i_start(r_start),
        .i_end(r_end), .o_speed(w_speed));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ModeCubic;
            r_start  <= '0;
            r_end    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMode:  r_mode  <= i_cfg_data[1:0];
                    CfgStart: r_start <= SW'(i_cfg_data);
                    CfgEnd:   r_end   <= SW'(i_cfg_data);
                    CfgCount: r_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_odata  <= w_const ? r_start : w_speed;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
